FILE: hw/rtl/ate_pkg.sv
// ----------------------------------------------------------------------------
// ANSI text terminal engine package
// Screen geometry, character codes, parser modes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ate_pkg;

  // Screen geometry and field widths.
  localparam int SCREEN_ROWS = 24;
  localparam int SCREEN_COLS = 80;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int CHAR_W      = 7;
  localparam int TOTAL_CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W      = $clog2(TOTAL_CELLS);
  localparam int PTR_W       = $clog2(TOTAL_CELLS + 1);

  // Character codes.
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_QUEST  = 8'h3f;
  localparam logic [7:0] CH_LBRACK = 8'h5b;

  // Control sequence final bytes.
  localparam logic [7:0] CSI_CUU = 8'h41;  // A
  localparam logic [7:0] CSI_CUD = 8'h42;  // B
  localparam logic [7:0] CSI_CUF = 8'h43;  // C
  localparam logic [7:0] CSI_CUB = 8'h44;  // D
  localparam logic [7:0] CSI_CUP = 8'h48;  // H
  localparam logic [7:0] CSI_ED  = 8'h4a;  // J
  localparam logic [7:0] CSI_EL  = 8'h4b;  // K
  localparam logic [7:0] CSI_HVP = 8'h66;  // f

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_CSI    = 2'd2
  } parser_mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_BLANK,
    ST_PUT,
    ST_DONE
  } ate_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic cell_load;
    logic scroll_rd;
    logic scroll_wr;
    logic blank_step;
    logic put;
    logic load_out;
  } ate_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic plan_read;
    logic plan_scroll;
    logic plan_blank;
    logic plan_put;
    logic blank_done;
    logic scroll_last;
    logic out_free;
  } ate_status_t;

  // Decimal parameter accumulation, saturating at 255.
  function automatic logic [7:0] acc_digit(input logic [7:0] v, input logic [3:0] d);
    logic [11:0] t;
    t = 12'(v) * 12'd10 + 12'(d);
    return (t > 12'd255) ? 8'hff : t[7:0];
  endfunction

endpackage

FILE: hw/rtl/ate_if.sv
// ----------------------------------------------------------------------------
// ANSI text terminal engine channels
// Request channel (byte feed or cell read) and response channel.
// ----------------------------------------------------------------------------
interface ate_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, command, data_byte, read_row, read_col, input ready);
  modport sink   (input valid, command, data_byte, read_row, read_col, output ready);
endinterface

interface ate_rsp_if;
  logic       valid;
  logic       ready;
  logic [6:0] cell_char;
  logic [4:0] cursor_row_out;
  logic [6:0] cursor_col_out;
  logic [1:0] parser_mode_out;

  modport source (output valid, cell_char, cursor_row_out, cursor_col_out, parser_mode_out,
                  input ready);
  modport sink   (input valid, cell_char, cursor_row_out, cursor_col_out, parser_mode_out,
                  output ready);
endinterface

FILE: hw/rtl/ate_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ate_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 1920
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ate_ctrl.sv
// ----------------------------------------------------------------------------
// ANSI text terminal engine controller
// Sequences the clearing pass, request decode, cell reads, scroll and erase
// sweeps, character writes and the response handoff.
// ----------------------------------------------------------------------------
module ate_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ate_pkg::ate_status_t status,
  output ate_pkg::ate_cmd_t    cmd
);
  import ate_pkg::*;

  ate_state_t state, state_next;
  logic       put_pend, put_pend_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      put_pend <= 1'b0;
    end else begin
      state    <= state_next;
      put_pend <= put_pend_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    put_pend_next = put_pend;
    cmd           = '0;
    req_ready     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (status.blank_done) begin
          state_next = ST_IDLE;
        end else begin
          cmd.blank_step = 1'b1;
        end
      end
      ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        put_pend_next = status.plan_put;
        priority if (status.plan_read) begin
          state_next = ST_READ;
        end else if (status.plan_scroll) begin
          state_next = ST_SCROLL_RD;
        end else if (status.plan_blank) begin
          state_next = ST_BLANK;
        end else if (status.plan_put) begin
          state_next = ST_PUT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        cmd.cell_load = 1'b1;
        state_next    = ST_DONE;
      end
      ST_SCROLL_RD: begin
        cmd.scroll_rd = 1'b1;
        state_next    = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        cmd.scroll_wr = 1'b1;
        state_next    = status.scroll_last ? ST_BLANK : ST_SCROLL_RD;
      end
      ST_BLANK: begin
        if (status.blank_done) begin
          state_next = put_pend ? ST_PUT : ST_DONE;
        end else begin
          cmd.blank_step = 1'b1;
        end
      end
      ST_PUT: begin
        cmd.put    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ate_datapath.sv
// ----------------------------------------------------------------------------
// ANSI text terminal engine datapath
// Holds the cursor, escape parser, sweep pointers, screen RAM and the
// response register, and decodes each request into a plan for the controller.
// ----------------------------------------------------------------------------
module ate_datapath #(
  parameter int PARAM_BUFFER_LEN = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ate_pkg::ate_cmd_t    cmd,
  output ate_pkg::ate_status_t status,
  input  logic                 req_command,
  input  logic [7:0]           req_data_byte,
  input  logic [4:0]           req_read_row,
  input  logic [6:0]           req_read_col,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic [6:0]           rsp_cell_char,
  output logic [4:0]           rsp_cursor_row_out,
  output logic [6:0]           rsp_cursor_col_out,
  output logic [1:0]           rsp_parser_mode_out
);
  import ate_pkg::*;

  localparam int CNT_W = (PARAM_BUFFER_LEN > 2) ? $clog2(PARAM_BUFFER_LEN) : 1;
  localparam logic [CNT_W-1:0] TAKEN_MAX = CNT_W'(PARAM_BUFFER_LEN - 1);
  localparam logic [PTR_W-1:0] P_TOTAL   = PTR_W'(TOTAL_CELLS);
  localparam logic [PTR_W-1:0] P_COLS    = PTR_W'(SCREEN_COLS);
  localparam logic [PTR_W-1:0] P_SCR_END = PTR_W'(TOTAL_CELLS - SCREEN_COLS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(SCREEN_COLS - 1);

  // Latched request.
  logic              item_command;
  logic [7:0]        item_byte;
  logic [ROW_W-1:0]  item_row;
  logic [COL_W-1:0]  item_col;

  // Terminal state.
  logic [ROW_W-1:0]  term_row, row_next;
  logic [COL_W-1:0]  term_col, col_next;
  parser_mode_t      mode, mode_next;
  logic [CNT_W-1:0]  taken, taken_next;
  logic [1:0]        field, field_next;
  logic [7:0]        p0, p0_next;
  logic [7:0]        p1, p1_next;

  // Sweep pointers and read result.
  logic [PTR_W-1:0]  ptr, hi;
  logic [PTR_W-1:0]  blank_lo, blank_hi;
  logic [CHAR_W-1:0] read_char;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  // Decode helpers.
  logic              is_digit, is_param, in_range;
  logic [3:0]        digit;
  logic [7:0]        n_cnt, h_row, h_col;
  logic [8:0]        sum_row, sum_col;
  logic [COL_W:0]    tab_col;
  logic [PTR_W-1:0]  row_base, cur_pos, item_pos;
  logic              plan_read, plan_scroll, plan_blank, plan_put;

  assign is_digit = (item_byte >= CH_ZERO) && (item_byte <= CH_NINE);
  assign is_param = is_digit || (item_byte == CH_SEMI) || (item_byte == CH_QUEST)
                    || (item_byte == CH_GT);
  assign digit    = 4'(item_byte - CH_ZERO);
  assign in_range = (item_row < ROW_W'(SCREEN_ROWS)) && (item_col < COL_W'(SCREEN_COLS));
  assign n_cnt    = (p0 != 8'd0) ? p0 : 8'd1;
  assign h_row    = n_cnt - 8'd1;
  assign h_col    = ((p1 != 8'd0) ? p1 : 8'd1) - 8'd1;
  assign sum_row  = 9'(term_row) + 9'(n_cnt);
  assign sum_col  = 9'(term_col) + 9'(n_cnt);
  assign tab_col  = ((COL_W+1)'(term_col) + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
  assign row_base = PTR_W'(term_row) * P_COLS;
  assign cur_pos  = row_base + PTR_W'(term_col);
  assign item_pos = PTR_W'(item_row) * P_COLS + PTR_W'(item_col);

  // Request decode: next terminal state and the sweep plan.
  always_comb begin
    row_next    = term_row;
    col_next    = term_col;
    mode_next   = mode;
    taken_next  = taken;
    field_next  = field;
    p0_next     = p0;
    p1_next     = p1;
    plan_read   = 1'b0;
    plan_scroll = 1'b0;
    plan_blank  = 1'b0;
    plan_put    = 1'b0;
    blank_lo    = '0;
    blank_hi    = '0;
    if (item_command) begin
      plan_read = 1'b1;
    end else begin
      unique case (mode)
        MODE_ESC: begin
          if (item_byte == CH_LBRACK) begin
            mode_next  = MODE_CSI;
            taken_next = '0;
            field_next = 2'd0;
            p0_next    = 8'd0;
            p1_next    = 8'd0;
          end else begin
            mode_next = MODE_NORMAL;
          end
        end
        MODE_CSI: begin
          if (is_param) begin
            // Only the first PARAM_BUFFER_LEN - 1 parameter characters are kept; later ones are dropped.
            if (taken != TAKEN_MAX) begin
              taken_next = taken + CNT_W'(1);
              if (item_byte == CH_SEMI) begin
                if (field != 2'd2) begin
                  field_next = field + 2'd1;
                end
              end else if (is_digit) begin
                if (field == 2'd0) begin
                  p0_next = acc_digit(p0, digit);
                end else if (field == 2'd1) begin
                  p1_next = acc_digit(p1, digit);
                end
              end
            end
          end else begin
            mode_next = MODE_NORMAL;
            unique case (item_byte)
              CSI_CUP, CSI_HVP: begin
                row_next = (h_row < 8'(SCREEN_ROWS)) ? ROW_W'(h_row) : ROW_LAST;
                col_next = (h_col < 8'(SCREEN_COLS)) ? COL_W'(h_col) : COL_LAST;
              end
              CSI_CUU: begin
                row_next = (n_cnt > 8'(term_row)) ? '0 : ROW_W'(8'(term_row) - n_cnt);
              end
              CSI_CUD: begin
                row_next = (sum_row >= 9'(SCREEN_ROWS)) ? ROW_LAST : ROW_W'(sum_row);
              end
              CSI_CUF: begin
                col_next = (sum_col >= 9'(SCREEN_COLS)) ? COL_LAST : COL_W'(sum_col);
              end
              CSI_CUB: begin
                col_next = (n_cnt > 8'(term_col)) ? '0 : COL_W'(8'(term_col) - n_cnt);
              end
              CSI_ED: begin
                if (p0 == 8'd2 || p0 == 8'd3) begin
                  plan_blank = 1'b1;
                  blank_lo   = '0;
                  blank_hi   = P_TOTAL;
                  row_next   = '0;
                  col_next   = '0;
                end else if (p0 == 8'd0) begin
                  // Cursor to end of screen is one contiguous address range.
                  plan_blank = 1'b1;
                  blank_lo   = cur_pos;
                  blank_hi   = P_TOTAL;
                end
              end
              CSI_EL: begin
                if (p0 == 8'd0) begin
                  plan_blank = 1'b1;
                  blank_lo   = cur_pos;
                  blank_hi   = row_base + P_COLS;
                end else if (p0 == 8'd1) begin
                  // A pending wrap erases up to the last column.
                  plan_blank = 1'b1;
                  blank_lo   = row_base;
                  blank_hi   = row_base + PTR_W'((term_col < COL_W'(SCREEN_COLS)) ?
                                                 term_col : COL_LAST) + PTR_W'(1);
                end else if (p0 == 8'd2) begin
                  plan_blank = 1'b1;
                  blank_lo   = row_base;
                  blank_hi   = row_base + P_COLS;
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
          unique case (item_byte)
            CH_ESC: mode_next = MODE_ESC;
            CH_CR:  col_next  = '0;
            CH_LF: begin
              col_next = '0;
              if (term_row == ROW_LAST) begin
                plan_scroll = 1'b1;
              end else begin
                row_next = term_row + ROW_W'(1);
              end
            end
            CH_BS: begin
              if (term_col != '0) begin
                col_next = term_col - COL_W'(1);
              end
            end
            CH_TAB: begin
              col_next = (tab_col >= (COL_W+1)'(SCREEN_COLS)) ? COL_LAST : COL_W'(tab_col);
            end
            default: begin
              if (item_byte >= CH_SPACE && item_byte < CH_DEL) begin
                plan_put = 1'b1;
                // Deferred wrap: a pending column does the newline first.
                if (term_col >= COL_W'(SCREEN_COLS)) begin
                  col_next = '0;
                  if (term_row == ROW_LAST) begin
                    plan_scroll = 1'b1;
                  end else begin
                    row_next = term_row + ROW_W'(1);
                  end
                end
              end
            end
          endcase
        end
      endcase
    end
  end

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_command <= req_command;
      item_byte    <= req_data_byte;
      item_row     <= req_read_row;
      item_col     <= req_read_col;
    end
  end

  // Terminal state, sweep pointers and read result.
  always_ff @(posedge clk) begin
    if (rst) begin
      term_row <= '0;
      term_col <= '0;
      mode     <= MODE_NORMAL;
      taken    <= '0;
      field    <= 2'd0;
      p0       <= 8'd0;
      p1       <= 8'd0;
      ptr      <= '0;
      hi       <= P_TOTAL;
    end else begin
      if (cmd.exec) begin
        term_row <= row_next;
        term_col <= col_next;
        mode     <= mode_next;
        taken    <= taken_next;
        field    <= field_next;
        p0       <= p0_next;
        p1       <= p1_next;
        if (plan_scroll) begin
          // The scroll ends with the pointer on the last row, then blanks it.
          ptr <= '0;
          hi  <= P_TOTAL;
        end else if (plan_blank) begin
          ptr <= blank_lo;
          hi  <= blank_hi;
        end
      end
      if (cmd.blank_step || cmd.scroll_wr) begin
        ptr <= ptr + PTR_W'(1);
      end
      if (cmd.put) begin
        term_col <= term_col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_char <= '0;
    end else if (cmd.cell_load) begin
      read_char <= in_range ? ram_rdata : CHAR_W'(CH_SPACE);
    end
  end

  // Screen RAM port selection.
  assign ram_we    = cmd.blank_step || cmd.scroll_wr || cmd.put;
  assign ram_waddr = cmd.put ? ADDR_W'(cur_pos) : ADDR_W'(ptr);
  assign ram_wdata = cmd.blank_step ? CHAR_W'(CH_SPACE) :
                     cmd.scroll_wr  ? ram_rdata : CHAR_W'(item_byte);
  assign ram_raddr = cmd.scroll_rd ? ADDR_W'(ptr + P_COLS) : ADDR_W'(item_pos);

  ate_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (TOTAL_CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_cell_char       <= read_char;
      rsp_cursor_row_out  <= term_row;
      rsp_cursor_col_out  <= term_col;
      rsp_parser_mode_out <= mode;
    end
  end

  // Status toward the controller.
  always_comb begin
    status.plan_read   = plan_read;
    status.plan_scroll = plan_scroll;
    status.plan_blank  = plan_blank;
    status.plan_put    = plan_put;
    status.blank_done  = (ptr >= hi);
    status.scroll_last = (ptr == P_SCR_END);
    status.out_free    = !rsp_valid || rsp_ready;
  end

`ifndef SYNTHESIS
  // The column rests at most one past the last column (pending wrap).
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    term_col <= COL_W'(SCREEN_COLS))
    else $error("cursor column beyond pending-wrap position");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    term_row < ROW_W'(SCREEN_ROWS))
    else $error("cursor row off screen");

  // Sweep writes stay inside the screen.
  a_sweep_addr: assert property (@(posedge clk) disable iff (rst)
    (cmd.blank_step || cmd.scroll_wr) |-> (ptr < P_TOTAL))
    else $error("sweep pointer outside the screen");

  // A character is only written after any pending wrap was resolved.
  a_put_col: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> (term_col < COL_W'(SCREEN_COLS)))
    else $error("character write at pending-wrap column");
`endif

endmodule

FILE: hw/rtl/ansi_text_terminal_engine_core.sv
// ----------------------------------------------------------------------------
// ANSI text terminal engine
// Byte-fed character terminal with escape parser, deferred wrap, scrolling,
// erase commands and single-cell readback.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                                              | Request
//  req     | in  | command, data_byte, read_row, read_col               | feed or read
//  rsp     | out | cell_char, cursor_row_out, cursor_col_out,           | one per req
//          |     | parser_mode_out                                      |
//
// A cursor move or parser byte passes through decode only; a cell read or plain character adds
// a RAM read or write. A scroll (line feed on the last row) copies each cell up one row with a
// read and a write through the one-read one-write screen RAM, then blanks the last row, and a
// following character is written after it; erases write one cell per step. After reset a
// clearing pass blanks the screen before the first request is taken. A result waits in the
// response register while the next request is accepted and processed.
module ansi_text_terminal_engine_core #(
  parameter int PARAM_BUFFER_LEN = 16
) (
  input  logic    clk,
  input  logic    rst,
  ate_req_if.sink   req,
  ate_rsp_if.source rsp
);
  import ate_pkg::*;

  ate_cmd_t    cmd;
  ate_status_t status;

  ate_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ate_datapath #(
    .PARAM_BUFFER_LEN (PARAM_BUFFER_LEN)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .req_command         (req.command),
    .req_data_byte       (req.data_byte),
    .req_read_row        (req.read_row),
    .req_read_col        (req.read_col),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_cell_char       (rsp.cell_char),
    .rsp_cursor_row_out  (rsp.cursor_row_out),
    .rsp_cursor_col_out  (rsp.cursor_col_out),
    .rsp_parser_mode_out (rsp.parser_mode_out)
  );

endmodule
